// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the RTL files.
// Each macro samples on clk_i and is disabled while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every clock edge outside reset.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that an antecedent implies a consequent in the next cycle.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/pop3lp_pkg.sv =====
// Package for the POP3 LIST reply parser: character codes, result codes,
// result record type and sizing defaults. No dependencies.
`timescale 1ns / 1ps

package pop3lp_pkg;

  localparam int unsigned DefaultFifoDepth = 4;

  localparam logic [7:0] ChPlus  = 8'h2B;
  localparam logic [7:0] ChO     = 8'h4F;
  localparam logic [7:0] ChK     = 8'h4B;
  localparam logic [7:0] ChCr    = 8'h0D;
  localparam logic [7:0] ChLf    = 8'h0A;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChNine  = 8'h39;

  localparam logic [31:0] FirstNewReset = 32'd1;

  typedef enum logic [1:0] {
    RES_HEADER  = 2'd0,
    RES_ENTRY   = 2'd1,
    RES_SUMMARY = 2'd2
  } result_type_e;

  typedef struct packed {
    result_type_e res_type;
    logic [31:0]  first_value;
    logic [31:0]  second_value;
    logic         is_new;
    logic         last_result;
  } result_t;

  function automatic logic [7:0] ok_byte(input logic [1:0] pos);
    logic [7:0] b;
    case (pos)
      2'd0:    b = ChPlus;
      2'd1:    b = ChO;
      2'd2:    b = ChK;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

// ===== rtl/pop3_list_response_parser_core.sv =====
// POP3 LIST reply parser core: input byte register, single-pass parse logic
// and a small result queue. Depends on pop3lp_pkg and assert_macros.svh.
`timescale 1ns / 1ps
// Usage:
//   Input channel (in_valid_i / in_ready_o) carries one reply byte per
//   transfer, with end_of_reply_i set on the final byte of a reply.
//   Config channel (cfg_valid_i / cfg_ready_o) writes first_new and is always
//   ready; users write it only while idle, which the block does not enforce.
//   Output channel (out_valid_o / out_ready_i) carries header, entry and
//   summary results in reply order.
//   Order: a byte accepted into the input register is parsed there and its
//   results go through the result queue; a final byte that also closes an
//   entry line gives its summary one output transfer later.
//   Throughput: one byte per cycle while the result queue has room, set by
//   the single parse pass on the input register; a byte that yields two
//   results needs two output transfers, absorbed by the FifoDepth-entry queue.
//   Stall: the input register advances only while the queue has room for two
//   results, so a stalled receiver backs up into in_ready_o low.
//   Reset: first_new returns to 1, parse state clears, queue empties.
`include "assert_macros.svh"

module pop3_list_response_parser_core #(
  parameter int unsigned FifoDepth = pop3lp_pkg::DefaultFifoDepth
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [7:0]               rx_byte_i,
  input  logic                     end_of_reply_i,
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [31:0]              cfg_first_new_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output pop3lp_pkg::result_type_e result_type_o,
  output logic [31:0]              first_value_o,
  output logic [31:0]              second_value_o,
  output logic                     is_new_o,
  output logic                     last_result_o
);
  import pop3lp_pkg::*;

  localparam int unsigned PtrW = (FifoDepth > 1) ? $clog2(FifoDepth) : 1;
  localparam int unsigned CntW = $clog2(FifoDepth + 1);
  localparam logic [CntW-1:0] RoomLimit = CntW'(FifoDepth - 2);
  localparam logic [PtrW-1:0] LastPtr   = PtrW'(FifoDepth - 1);

  typedef enum logic [1:0] {
    PH_PREFIX  = 2'd0,
    PH_HEADER  = 2'd1,
    PH_ENTRIES = 2'd2,
    PH_IGNORE  = 2'd3
  } phase_e;

  logic [31:0] first_new_q;

  logic        s1_valid_q;
  logic [7:0]  s1_byte_q;
  logic        s1_last_q;
  logic        s1_adv;

  phase_e      phase_q, phase_d;
  logic [1:0]  prefix_pos_q, prefix_pos_d;
  logic [1:0]  field_idx_q, field_idx_d;
  logic        saw_cr_q, saw_cr_d;
  logic        stopped_q, stopped_d;
  logic [31:0] first_acc_q, first_acc_d;
  logic [31:0] second_acc_q, second_acc_d;
  logic [31:0] entry_cnt_q, entry_cnt_d;

  result_t     line_res, sum_res;
  logic        line_emit;

  logic [1:0]  slot_first;
  logic [31:0] acc_sel;
  logic [35:0] acc_prod;
  logic [31:0] acc_next;

  result_t         fifo_q [FifoDepth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, wr_ptr_nx, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [1:0]      push_n;
  logic            pop;

  assign cfg_ready_o = 1'b1;
  assign s1_adv      = s1_valid_q && (cnt_q <= RoomLimit);
  assign in_ready_o  = !s1_valid_q || s1_adv;

  // digit accumulate with saturation, shared by both number fields
  assign slot_first = (phase_q == PH_HEADER) ? 2'd1 : 2'd0;
  assign acc_sel    = (field_idx_q == slot_first) ? first_acc_q : second_acc_q;
  assign acc_prod   = {1'b0, acc_sel, 3'b000} + {3'b000, acc_sel, 1'b0}
                    + {32'd0, s1_byte_q[3:0] - ChZero[3:0]};
  assign acc_next   = (|acc_prod[35:32]) ? 32'hFFFF_FFFF : acc_prod[31:0];

  always_comb begin
    phase_d      = phase_q;
    prefix_pos_d = prefix_pos_q;
    field_idx_d  = field_idx_q;
    saw_cr_d     = saw_cr_q;
    stopped_d    = stopped_q;
    first_acc_d  = first_acc_q;
    second_acc_d = second_acc_q;
    entry_cnt_d  = entry_cnt_q;
    line_emit    = 1'b0;
    line_res     = '{res_type: RES_HEADER, first_value: first_acc_q,
                     second_value: second_acc_q, is_new: 1'b0, last_result: 1'b0};
    case (phase_q)
      PH_PREFIX: begin
        if (s1_byte_q == ok_byte(prefix_pos_q)) begin
          prefix_pos_d = prefix_pos_q + 2'd1;
          if (prefix_pos_q == 2'd2) begin
            phase_d = PH_HEADER;
          end
        end else begin
          phase_d = PH_IGNORE;
        end
      end
      PH_HEADER, PH_ENTRIES: begin
        if (s1_byte_q == ChLf && saw_cr_q) begin
          if (phase_q == PH_HEADER) begin
            line_emit = 1'b1;
            phase_d   = PH_ENTRIES;
          end else if (first_acc_q != 32'd0 && second_acc_q != 32'd0) begin
            line_emit         = 1'b1;
            line_res.res_type = RES_ENTRY;
            line_res.is_new   = (first_acc_q >= first_new_q);
            entry_cnt_d       = entry_cnt_q + 32'd1;
          end
          field_idx_d  = 2'd0;
          saw_cr_d     = 1'b0;
          stopped_d    = 1'b0;
          first_acc_d  = 32'd0;
          second_acc_d = 32'd0;
        end else begin
          saw_cr_d = (s1_byte_q == ChCr);
          if (s1_byte_q == ChSpace) begin
            if (field_idx_q != 2'd3) begin
              field_idx_d = field_idx_q + 2'd1;
            end
            stopped_d = 1'b0;
          end else if (s1_byte_q inside {[ChZero:ChNine]} && !stopped_q) begin
            if (field_idx_q == slot_first) begin
              first_acc_d = acc_next;
            end else if (field_idx_q == slot_first + 2'd1) begin
              second_acc_d = acc_next;
            end
          end else begin
            stopped_d = 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
    sum_res = '{res_type: RES_SUMMARY, first_value: entry_cnt_d,
                second_value: entry_cnt_d - first_new_q + 32'd1,
                is_new: 1'b0, last_result: 1'b1};
  end

  // input register, config register and parse state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q   <= 1'b0;
      first_new_q  <= FirstNewReset;
      phase_q      <= PH_PREFIX;
      prefix_pos_q <= 2'd0;
      field_idx_q  <= 2'd0;
      saw_cr_q     <= 1'b0;
      stopped_q    <= 1'b0;
      first_acc_q  <= 32'd0;
      second_acc_q <= 32'd0;
      entry_cnt_q  <= 32'd0;
    end else begin
      if (cfg_valid_i) begin
        first_new_q <= cfg_first_new_i;
      end
      if (in_ready_o) begin
        s1_valid_q <= in_valid_i;
      end
      if (s1_adv) begin
        if (s1_last_q) begin
          phase_q      <= PH_PREFIX;
          prefix_pos_q <= 2'd0;
          field_idx_q  <= 2'd0;
          saw_cr_q     <= 1'b0;
          stopped_q    <= 1'b0;
          first_acc_q  <= 32'd0;
          second_acc_q <= 32'd0;
          entry_cnt_q  <= 32'd0;
        end else begin
          phase_q      <= phase_d;
          prefix_pos_q <= prefix_pos_d;
          field_idx_q  <= field_idx_d;
          saw_cr_q     <= saw_cr_d;
          stopped_q    <= stopped_d;
          first_acc_q  <= first_acc_d;
          second_acc_q <= second_acc_d;
          entry_cnt_q  <= entry_cnt_d;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      s1_byte_q <= rx_byte_i;
      s1_last_q <= end_of_reply_i;
    end
  end

  // result queue
  assign pop       = (cnt_q != '0) && out_ready_i;
  assign wr_ptr_nx = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + PtrW'(1);

  always_comb begin
    push_n = 2'd0;
    if (s1_adv) begin
      push_n = {1'b0, line_emit} + {1'b0, s1_last_q};
    end
    wr_ptr_d = wr_ptr_q;
    case (push_n)
      2'd1:    wr_ptr_d = wr_ptr_nx;
      2'd2:    wr_ptr_d = (wr_ptr_nx == LastPtr) ? '0 : wr_ptr_nx + PtrW'(1);
      default: wr_ptr_d = wr_ptr_q;
    endcase
    rd_ptr_d = rd_ptr_q;
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + PtrW'(1);
    end
    cnt_d = cnt_q + CntW'(push_n) - CntW'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      if (line_emit) begin
        fifo_q[wr_ptr_q] <= line_res;
        if (s1_last_q) begin
          fifo_q[wr_ptr_nx] <= sum_res;
        end
      end else if (s1_last_q) begin
        fifo_q[wr_ptr_q] <= sum_res;
      end
    end
  end

  assign out_valid_o    = (cnt_q != '0);
  assign result_type_o  = fifo_q[rd_ptr_q].res_type;
  assign first_value_o  = fifo_q[rd_ptr_q].first_value;
  assign second_value_o = fifo_q[rd_ptr_q].second_value;
  assign is_new_o       = fifo_q[rd_ptr_q].is_new;
  assign last_result_o  = fifo_q[rd_ptr_q].last_result;

  `ASSERT_CLK(a_cnt_bound, cnt_q <= CntW'(FifoDepth), "result queue overflow")
  `ASSERT_CLK(a_last_is_sum, !out_valid_o || !last_result_o || result_type_o == RES_SUMMARY, "last flag on non-summary result")
  `ASSERT_CLK(a_new_is_entry, !out_valid_o || !is_new_o || result_type_o == RES_ENTRY, "new flag on non-entry result")
  `ASSERT_NEXT(a_reply_restart, s1_adv && s1_last_q, phase_q == PH_PREFIX && entry_cnt_q == 32'd0, "parse state not cleared after final byte")

endmodule

// ===== dv/pop3_list_result_checker.sv =====
// Checker for the POP3 LIST reply parser: watches the byte, config and result channels,
// predicts header, entry and summary results per accepted byte and compares them in order.
// Depends on pop3lp_pkg for the character codes and the result record type.
`timescale 1ns / 1ps

module pop3_list_result_checker (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  input  logic                     in_ready_i,
  input  logic [7:0]               rx_byte_i,
  input  logic                     end_of_reply_i,
  input  logic                     cfg_valid_i,
  input  logic                     cfg_ready_i,
  input  logic [31:0]              cfg_first_new_i,
  input  logic                     out_valid_i,
  input  logic                     out_ready_i,
  input  pop3lp_pkg::result_type_e result_type_i,
  input  logic [31:0]              first_value_i,
  input  logic [31:0]              second_value_i,
  input  logic                     is_new_i,
  input  logic                     last_result_i,
  output int unsigned              mismatch_count_o,
  output int unsigned              results_due_o,
  output int unsigned              results_checked_o
);
  import pop3lp_pkg::*;

  typedef enum logic [1:0] {
    MATCH_OK     = 2'd0,
    READ_HEADER  = 2'd1,
    READ_ENTRIES = 2'd2,
    SKIP_REPLY   = 2'd3
  } list_phase_e;

  list_phase_e  list_phase;
  logic [1:0]   ok_pos;
  logic [1:0]   field_idx;
  logic         cr_seen;
  logic         digits_done;
  logic [31:0]  number_acc;
  logic [31:0]  size_acc;
  logic [31:0]  entries_seen;
  logic [31:0]  first_new;
  result_t      listing_results_due[$];
  result_t      want;
  int unsigned  mismatches;
  int unsigned  checked;

  function automatic logic [31:0] append_digit(input logic [31:0] acc, input logic [7:0] ch);
    logic [63:0] wide;
    wide = {32'd0, acc} * 64'd10 + 64'(ch - ChZero);
    return (wide > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : wide[31:0];
  endfunction

  task automatic clear_line();
    field_idx   = 2'd0;
    cr_seen     = 1'b0;
    digits_done = 1'b0;
    number_acc  = '0;
    size_acc    = '0;
  endtask

  task automatic clear_reply();
    list_phase   = MATCH_OK;
    ok_pos       = 2'd0;
    entries_seen = '0;
    clear_line();
  endtask

  task automatic queue_listing_result(input result_type_e kind, input logic [31:0] a,
                                      input logic [31:0] b, input logic fresh,
                                      input logic closing);
    result_t r;
    r.res_type     = kind;
    r.first_value  = a;
    r.second_value = b;
    r.is_new       = fresh;
    r.last_result  = closing;
    listing_results_due.push_back(r);
  endtask

  task automatic parse_list_byte(input logic [7:0] ch, input logic closing);
    logic [7:0] ok_char;
    logic       in_header;
    logic [1:0] slot;
    case (list_phase)
      MATCH_OK: begin
        ok_char = (ok_pos == 2'd0) ? ChPlus : (ok_pos == 2'd1) ? ChO : ChK;
        if (ch == ok_char) begin
          if (ok_pos == 2'd2) list_phase = READ_HEADER;
          ok_pos = ok_pos + 2'd1;
        end else begin
          list_phase = SKIP_REPLY;
        end
      end
      READ_HEADER, READ_ENTRIES: begin
        in_header = (list_phase == READ_HEADER);
        if (ch == ChLf && cr_seen) begin
          if (in_header) begin
            queue_listing_result(RES_HEADER, number_acc, size_acc, 1'b0, 1'b0);
            list_phase = READ_ENTRIES;
          end else if (number_acc != 0 && size_acc != 0) begin
            queue_listing_result(RES_ENTRY, number_acc, size_acc,
                                 number_acc >= first_new, 1'b0);
            entries_seen = entries_seen + 32'd1;
          end
          clear_line();
        end else begin
          cr_seen = (ch == ChCr);
          if (ch == ChSpace) begin
            if (field_idx < 2'd3) field_idx = field_idx + 2'd1;
            digits_done = 1'b0;
          end else if (ch >= ChZero && ch <= ChNine && !digits_done) begin
            slot = in_header ? 2'd1 : 2'd0;
            if (field_idx == slot) begin
              number_acc = append_digit(number_acc, ch);
            end else if (field_idx == slot + 2'd1) begin
              size_acc = append_digit(size_acc, ch);
            end
          end else begin
            digits_done = 1'b1;
          end
        end
      end
      default: ;
    endcase
    if (closing) begin
      queue_listing_result(RES_SUMMARY, entries_seen, entries_seen - first_new + 32'd1,
                           1'b0, 1'b1);
      clear_reply();
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_reply();
      first_new = FirstNewReset;
      listing_results_due.delete();
      mismatches = 0;
      checked    = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (listing_results_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("%0t: unexpected result: type %0d first %0d second %0d new %b last %b",
                     $realtime, result_type_i, first_value_i, second_value_i, is_new_i,
                     last_result_i);
          end
        end else begin
          want = listing_results_due.pop_front();
          checked++;
          if (want.res_type !== result_type_i || want.first_value !== first_value_i ||
              want.second_value !== second_value_i || want.is_new !== is_new_i ||
              want.last_result !== last_result_i) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("%0t: result mismatch: expected type %0d first %0d second %0d new %b last %b",
                       $realtime, want.res_type, want.first_value, want.second_value,
                       want.is_new, want.last_result);
              $display("%0t:                  actual type %0d first %0d second %0d new %b last %b",
                       $realtime, result_type_i, first_value_i, second_value_i, is_new_i,
                       last_result_i);
            end
          end
        end
      end
      if (cfg_valid_i && cfg_ready_i) first_new = cfg_first_new_i;
      if (in_valid_i && in_ready_i) parse_list_byte(rx_byte_i, end_of_reply_i);
    end
    mismatch_count_o  <= mismatches;
    results_due_o     <= listing_results_due.size();
    results_checked_o <= checked;
  end

endmodule

// ===== dv/testbench.sv =====
// Top of the POP3 LIST reply parser testbench: clock, reset, reply stimulus, receiver
// stalls and verdict. Depends on pop3lp_pkg, pop3_list_response_parser_core and
// pop3_list_result_checker.
`timescale 1ns / 1ps

module testbench;
  import pop3lp_pkg::*;

  localparam int unsigned SettleCycles   = 4;
  localparam int unsigned LongHoldCycles = 120;
  localparam int unsigned PhaseBytes     = 250;
  localparam logic [7:0]  ChDot          = 8'h2E;
  localparam logic [7:0]  ChLowA         = 8'h61;
  localparam logic [7:0]  ChLowZ         = 8'h7A;

  logic         clk_i           = 1'b0;
  logic         rst_ni          = 1'b0;
  logic         in_valid_i      = 1'b0;
  logic [7:0]   rx_byte_i       = 8'h00;
  logic         end_of_reply_i  = 1'b0;
  logic         cfg_valid_i     = 1'b0;
  logic [31:0]  cfg_first_new_i = 32'd0;
  logic         out_ready_i     = 1'b0;
  logic         in_ready_o;
  logic         cfg_ready_o;
  logic         out_valid_o;
  result_type_e result_type_o;
  logic [31:0]  first_value_o;
  logic [31:0]  second_value_o;
  logic         is_new_o;
  logic         last_result_o;

  int unsigned  mismatches;
  int unsigned  results_due;
  int unsigned  results_checked;
  int unsigned  send_idle_pct  = 0;
  int unsigned  recv_stall_pct = 0;
  logic         long_hold_req  = 1'b0;
  logic         long_hold_done = 1'b0;
  int unsigned  bytes_sent     = 0;
  int unsigned  listing_bytes  = 0;
  int unsigned  replies_sent   = 0;
  logic [7:0]   reply_text[$];

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  pop3_list_response_parser_core u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .rx_byte_i       (rx_byte_i),
    .end_of_reply_i  (end_of_reply_i),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_first_new_i (cfg_first_new_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .result_type_o   (result_type_o),
    .first_value_o   (first_value_o),
    .second_value_o  (second_value_o),
    .is_new_o        (is_new_o),
    .last_result_o   (last_result_o)
  );

  pop3_list_result_checker u_checker (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_ready_i        (in_ready_o),
    .rx_byte_i         (rx_byte_i),
    .end_of_reply_i    (end_of_reply_i),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_ready_i       (cfg_ready_o),
    .cfg_first_new_i   (cfg_first_new_i),
    .out_valid_i       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .result_type_i     (result_type_o),
    .first_value_i     (first_value_o),
    .second_value_i    (second_value_o),
    .is_new_i          (is_new_o),
    .last_result_i     (last_result_o),
    .mismatch_count_o  (mismatches),
    .results_due_o     (results_due),
    .results_checked_o (results_checked)
  );

  // hold off the receiver for a long stretch on request, else stall at random
  initial begin
    forever begin
      @(posedge clk_i);
      if (long_hold_req && !long_hold_done) begin
        out_ready_i <= 1'b0;
        repeat (LongHoldCycles - 1) @(posedge clk_i);
        long_hold_done = 1'b1;
      end else begin
        out_ready_i <= ($urandom_range(99, 0) >= recv_stall_pct);
      end
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic closing);
    while ($urandom_range(99, 0) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    rx_byte_i      <= b;
    end_of_reply_i <= closing;
    do @(posedge clk_i); while (!in_ready_o);
    bytes_sent++;
  endtask

  task automatic send_reply();
    if (reply_text.size() >= 3 && reply_text[0] == ChPlus && reply_text[1] == ChO &&
        reply_text[2] == ChK) begin
      listing_bytes += reply_text.size();
    end
    foreach (reply_text[i]) send_byte(reply_text[i], i == reply_text.size() - 1);
    replies_sent++;
    reply_text.delete();
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (results_due != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_first_new(input logic [31:0] value);
    cfg_valid_i     <= 1'b1;
    cfg_first_new_i <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic put_text(input string s);
    foreach (s[i]) reply_text.push_back(s[i]);
  endtask

  task automatic put_line_end();
    reply_text.push_back(ChCr);
    reply_text.push_back(ChLf);
  endtask

  task automatic put_number();
    logic [63:0] v;
    logic [7:0]  digits[$];
    case ($urandom_range(9, 0))
      0:       v = 64'd0;
      1, 2, 3: v = 64'($urandom_range(12, 1));
      4:       v = 64'($urandom_range(99999, 1));
      5:       v = 64'($urandom);
      6:       v = 64'hFFFF_FFFF;
      7:       v = 64'h1_0000_0000 + 64'($urandom_range(9, 0));
      8:       v = {$urandom, $urandom};
      default: begin
        reply_text.push_back(ChZero);
        v = 64'($urandom_range(20, 1));
      end
    endcase
    do begin
      digits.push_front(ChZero + 8'(v % 64'd10));
      v = v / 64'd10;
    end while (v != 0);
    foreach (digits[i]) reply_text.push_back(digits[i]);
  endtask

  task automatic put_line(input logic in_header);
    int shape;
    shape = $urandom_range(9, 0);
    if (in_header) reply_text.push_back(ChSpace);
    put_number();
    if (shape != 0) reply_text.push_back(ChSpace);
    if (shape == 1) reply_text.push_back(ChSpace);
    put_number();
    case (shape)
      2: begin
        reply_text.push_back(ChSpace);
        repeat (3) reply_text.push_back(8'($urandom_range(ChLowZ, ChLowA)));
      end
      3: begin
        reply_text.push_back(8'($urandom_range(ChLowZ, ChLowA)));
        put_number();
      end
      4: begin
        reply_text.push_back(ChCr);
        put_number();
      end
      5: begin
        repeat (2) begin
          reply_text.push_back(ChSpace);
          put_number();
        end
      end
      default: ;
    endcase
    put_line_end();
  endtask

  task automatic build_reply();
    int kind;
    int cut;
    kind = $urandom_range(99, 0);
    if (kind < 10) begin
      repeat ($urandom_range(12, 1)) reply_text.push_back(8'($urandom_range(255, 0)));
    end else begin
      reply_text.push_back(ChPlus);
      reply_text.push_back(ChO);
      reply_text.push_back(ChK);
      if (kind < 20) reply_text[$urandom_range(2, 0)] = 8'($urandom_range(255, 0));
      put_line(1'b1);
      repeat ($urandom_range(6, 0)) put_line(1'b0);
      if ($urandom_range(1, 0) == 1) begin
        reply_text.push_back(ChDot);
        put_line_end();
      end
      if (kind >= 90) begin
        cut = $urandom_range(reply_text.size(), 1);
        while (reply_text.size() > cut) void'(reply_text.pop_back());
      end
    end
  endtask

  initial begin
    logic [31:0] first_new_pick;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    write_first_new(32'd3);

    // header, an entry closed by the final byte, then bad prefix and early ends
    put_text("+OK 1 5");
    put_line_end();
    put_text("3 4");
    put_line_end();
    send_reply();
    put_text("-");
    send_reply();
    put_text("+OK");
    send_reply();
    reply_text.push_back(8'h00);
    send_reply();
    reply_text.push_back(8'hFF);
    send_reply();

    for (int phase = 0; phase < 4; phase++) begin
      drain_results();
      case (phase)
        0:       first_new_pick = 32'd0;
        1:       first_new_pick = 32'hFFFF_FFFF;
        2:       first_new_pick = 32'($urandom_range(8, 1));
        default: first_new_pick = FirstNewReset;
      endcase
      write_first_new(first_new_pick);
      send_idle_pct  = (phase == 1) ? 53 : (phase == 3) ? 18 : 0;
      recv_stall_pct = (phase == 2) ? 53 : (phase == 3) ? 18 : 0;
      if (phase == 2) long_hold_req = 1'b1;
      while (listing_bytes < PhaseBytes * (phase + 1)) begin
        build_reply();
        send_reply();
      end
    end
    drain_results();

    $display("Run covered %0d reply bytes over %0d replies (%0d in +OK listings), %0d results",
             bytes_sent, replies_sent, listing_bytes, results_checked);
    $display("checked across five first_new settings and four idle and stall patterns");
    if (mismatches == 0 && results_due == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("TEST FAILED");
    $finish;
  end

endmodule
